// ----- sv/sfm_pkg.sv -----
// ----------------------------------------------------------------------------
// sfm_pkg
// Types and constants shared by the single-precision multiplier.
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;
    localparam logic [9:0]  FP_BIAS   = 10'h07F;

    // special-case class decided in the first stage
    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } cls_t;

endpackage

// ----- sv/single_float_multiply_unit.sv -----
// throughput: one operand pair per cycle while m_ready does not stall the output, four register stages
// stages: unpack, 24x24 multiply, leading-one normalise, pack
// a stall holds the valid stages up to the first bubble; bubbles are squeezed out
// reset: synchronous active-low aresetn clears the stage valid bits
// ----------------------------------------------------------------------------
// single_float_multiply_unit
// Single-precision multiplier, round toward zero, denormal results flushed.
// ----------------------------------------------------------------------------
module single_float_multiply_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_product
);
    import sfm_pkg::*;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = v4_reg;

    // ---------------- stage 1: unpack ----------------
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        za, zb, na, nb, ia, ib, da, db;
    cls_t        cls1_next;
    logic        sgn1_reg;
    cls_t        cls1_reg;
    logic [23:0] sa1_reg, sb1_reg;
    logic [9:0]  exp1_reg;

    always_comb begin
        ea = s_operand_a[30:23];
        eb = s_operand_b[30:23];
        fa = s_operand_a[22:0];
        fb = s_operand_b[22:0];
        za = (ea == 8'd0) && (fa == 23'd0);
        zb = (eb == 8'd0) && (fb == 23'd0);
        da = (ea == 8'd0);
        db = (eb == 8'd0);
        na = (ea == EXP_MAX) && (fa != 23'd0);
        nb = (eb == EXP_MAX) && (fb != 23'd0);
        ia = (ea == EXP_MAX);
        ib = (eb == EXP_MAX);
        if (na || nb)                    cls1_next = CLS_NAN;
        else if ((ia || ib) && (za || zb)) cls1_next = CLS_NAN;
        else if (ia || ib)               cls1_next = CLS_INF;
        else if (za || zb || (da && db)) cls1_next = CLS_ZERO;
        else                             cls1_next = CLS_NORMAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_valid;
        end
        if (adv1) begin
            sgn1_reg <= s_operand_a[31] ^ s_operand_b[31];
            cls1_reg <= cls1_next;
            sa1_reg  <= {!da, fa};
            sb1_reg  <= {!db, fb};
            exp1_reg <= {2'b00, (da ? 8'd1 : ea)} + {2'b00, (db ? 8'd1 : eb)} - FP_BIAS;
        end
    end

    // ---------------- stage 2: multiply ----------------
    logic        sgn2_reg;
    cls_t        cls2_reg;
    logic [47:0] prod2_reg;
    logic [9:0]  exp2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2) begin
            sgn2_reg  <= sgn1_reg;
            cls2_reg  <= cls1_reg;
            prod2_reg <= sa1_reg * sb1_reg;
            exp2_reg  <= exp1_reg;
        end
    end

    // ---------------- stage 3: normalise ----------------
    logic [5:0]  lz;
    logic [47:0] mant3_next;
    logic [9:0]  exp3_next;
    logic        sgn3_reg;
    cls_t        cls3_reg;
    logic [22:0] frac3_reg;
    logic [9:0]  exp3_reg;

    always_comb begin
        // distance from bit 46 down to the leading one
        lz = 6'd0;
        for (int i = 0; i <= 46; i++) begin
            if (prod2_reg[i]) lz = 6'(46 - i);
        end
        if (prod2_reg[47]) begin
            mant3_next = prod2_reg >> 24;
            exp3_next  = exp2_reg + 10'd1;
        end else if (prod2_reg[46]) begin
            mant3_next = prod2_reg >> 23;
            exp3_next  = exp2_reg;
        end else begin
            mant3_next = (prod2_reg << lz) >> 23;
            exp3_next  = exp2_reg - {4'd0, lz};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3) begin
            sgn3_reg  <= sgn2_reg;
            cls3_reg  <= cls2_reg;
            frac3_reg <= mant3_next[22:0];
            exp3_reg  <= exp3_next;
        end
    end

    // ---------------- stage 4: pack ----------------
    logic [31:0] prod4_next;
    logic [31:0] prod4_reg;

    always_comb begin
        case (cls3_reg)
            CLS_NAN:  prod4_next = QUIET_NAN;
            CLS_INF:  prod4_next = {sgn3_reg, EXP_MAX, 23'd0};
            CLS_ZERO: prod4_next = {sgn3_reg, 31'd0};
            default: begin
                // exponent is signed in ten bits
                if (exp3_reg[9] || exp3_reg == 10'd0)
                    prod4_next = {sgn3_reg, 31'd0};
                else if (exp3_reg >= {2'b00, EXP_MAX})
                    prod4_next = {sgn3_reg, EXP_MAX, 23'd0};
                else
                    prod4_next = {sgn3_reg, exp3_reg[7:0], frac3_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv4) begin
            v4_reg <= v3_reg;
        end
        if (adv4) begin
            prod4_reg <= prod4_next;
        end
    end

    assign m_product = prod4_reg;

endmodule

// ----- sim/tb_single_float_multiply_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_float_multiply_unit
// Drives operand pairs into the truncating single-precision multiplier
// through a bursty sender. A stalling receiver takes the products, and each
// one is checked against a bit-exact predictor of the product.
// ----------------------------------------------------------------------------
module tb_single_float_multiply_unit;
    import sfm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_product;

    logic [31:0] pending_products[$];
    int          fail_count = 0;
    int          products_seen = 0;
    int          pairs_sent = 0;
    longint      cycle_count = 0;
    bit          burst_mode = 1'b1;

    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [31:0] EXP_FIELD  = 32'h7F80_0000;
    localparam logic [31:0] FRAC_FIELD = 32'h007F_FFFF;

    single_float_multiply_unit dut (.*);

    always #5 aclk = ~aclk;

    // truncating product, denormal results flushed
    function automatic logic [31:0] fp_product(logic [31:0] a, logic [31:0] b);
        logic [31:0] sgn;
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic [47:0] sa, sb, prod, mant;
        int          ex, lead, shift;
        sgn = (a ^ b) & SIGN_BIT;
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        if ((ea == EXP_MAX && fa != 0) || (eb == EXP_MAX && fb != 0)) return QUIET_NAN;
        if (ea == EXP_MAX || eb == EXP_MAX) begin
            if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return QUIET_NAN;
            return sgn | EXP_FIELD;
        end
        if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return sgn;
        if (ea == 0 && eb == 0) return sgn;
        sa = (ea == 0) ? {25'd0, fa} : {24'd0, 1'b1, fa};
        sb = (eb == 0) ? {25'd0, fb} : {24'd0, 1'b1, fb};
        ex = ((ea == 0) ? 1 : int'(ea)) + ((eb == 0) ? 1 : int'(eb)) - int'(FP_BIAS);
        prod = sa * sb;
        if (prod[47]) begin
            mant = prod >> 24;
            ex += 1;
        end else if (prod[46]) begin
            mant = prod >> 23;
        end else begin
            lead = 0;
            for (int i = 0; i < 48; i++) if (prod[i]) lead = i;
            shift = 46 - lead;
            ex -= shift;
            mant = (prod << shift) >> 23;
        end
        if (ex >= int'(EXP_MAX)) return sgn | EXP_FIELD;
        if (ex <= 0) return sgn;
        return sgn | (32'(ex) << 23) | (mant[31:0] & FRAC_FIELD);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (cycle_count % 600 < 150) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            products_seen++;
            if (pending_products.size() == 0) begin
                $error("unexpected product transfer %08h", m_product);
                fail_count++;
            end else begin
                want = pending_products.pop_front();
                if (m_product !== want) begin
                    $error("product: expected %08h actual %08h", want, m_product);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        if (burst_mode && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_products.push_back(fp_product(a, b));
        pairs_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_products();
        go_idle();
        while (pending_products.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = EXP_MAX;
            2: v[30:0]  = '0;
            3: v[30:23] = 8'($urandom_range(1, 8));
            4: v[30:23] = 8'($urandom_range(240, 254));
            5: v[22:0]  = (v[0]) ? '0 : 23'h7F_FFFF;
            default: v[30:23] = 8'($urandom_range(64, 190));
        endcase
        return v;
    endfunction

    task automatic test_special_cases();
        send_pair(32'h7FC0_0001, 32'h3F80_0000);   // nan operand
        send_pair(32'h3F80_0000, 32'hFF80_0001);
        send_pair(32'h7F80_0000, 32'h0000_0000);   // infinity times zero
        send_pair(32'h8000_0000, 32'hFF80_0000);
        send_pair(32'h7F80_0000, 32'hC000_0000);   // signed infinity
        send_pair(32'hFF80_0000, 32'h0000_0001);   // infinity times denormal
        send_pair(32'h8000_0000, 32'h4049_0FDB);   // signed zero
        send_pair(32'h0040_0000, 32'h8000_0001);   // two denormals
        send_pair(32'h0040_0000, 32'h4B00_0000);   // single denormal
        send_pair(32'h0000_0001, 32'h7F7F_FFFF);   // missing leading one
        send_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);   // carry into bit 47
        send_pair(32'h3F80_0000, 32'h3F80_0000);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
        send_pair(32'h0080_0000, 32'h0080_0000);   // underflow
        send_pair(32'h0080_0000, 32'h3F00_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        drain_products();
    endtask

    task automatic test_back_to_back();
        burst_mode = 1'b0;
        repeat (300) send_pair(pick_operand(), pick_operand());
        burst_mode = 1'b1;
        drain_products();
    endtask

    task automatic test_random_bursts();
        repeat (1700) send_pair(pick_operand(), pick_operand());
        go_idle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_back_to_back();
        test_random_bursts();
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered special operands, back-to-back and bursty traffic");
        $display("%0d pairs sent, %0d products checked", pairs_sent, products_seen);
        if (fail_count == 0 && pending_products.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- single_float_multiply_unit.f -----
sv/sfm_pkg.sv
sv/single_float_multiply_unit.sv
sim/tb_single_float_multiply_unit.sv
